// ===== design/ifps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and register codes of the input event frame phase stamper.
// Depends on nothing; ifps_div, the top level and the checker import it.
package ifps_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned PHASE_BITS      = 16;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam int unsigned NW              = $clog2(MAX_RESULTS + 1);

  localparam logic [PHASE_BITS:0] PHASE_ONE = {1'b1, {PHASE_BITS{1'b0}}};

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  localparam logic [31:0] RST_DEBOUNCE_TICKS = 32'd200000;
  localparam logic [31:0] RST_FRAME_TICKS    = 32'd4166666;

  typedef enum logic [1:0] {
    REG_ENABLE      = 2'd0,
    REG_DEB_ENABLE  = 2'd1,
    REG_DEB_TICKS   = 2'd2,
    REG_FRAME_TICKS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        cmd;
    logic [63:0] stamp;
    logic [1:0]  button;
    logic        is_press;
    logic        second_player;
  } in_word_t;

  typedef struct packed {
    logic [63:0]         event_stamp;
    logic [1:0]          event_button;
    logic                event_press;
    logic                event_player_two;
    logic [PHASE_BITS:0] phase;
    logic                last;
  } out_word_t;

  typedef struct packed {
    logic        player_two;
    logic        press;
    logic [1:0]  button;
    logic [63:0] stamp;
  } q_entry_t;

  typedef struct packed {
    logic                  done;
    logic [PHASE_BITS-1:0] quo;
  } div_rsp_t;

endpackage

// ===== design/ifps_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ifps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ifps_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider that produces the fraction bits of rem / span.
// Depends on ifps_pkg.
module ifps_div
  import ifps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rem_i,
  input  logic [63:0] span_i,
  output div_rsp_t    rsp_o
);

  localparam int unsigned CNTW = $clog2(PHASE_BITS + 1);

  logic [63:0]           rem_q;
  logic [63:0]           span_q;
  logic [PHASE_BITS-1:0] quo_q;
  logic [CNTW-1:0]       cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [64:0] shifted;
  logic [64:0] diff;
  logic        take;

  // The remainder stays below span, so the doubled value fits in 65 bits.
  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, span_q};
  assign take    = (shifted >= {1'b0, span_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(PHASE_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      span_q <= span_i;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= take ? diff[63:0] : shifted[63:0];
      quo_q <= {quo_q[PHASE_BITS-2:0], take};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== design/input_event_frame_phase_stamper_top.sv =====
`timescale 1ns / 1ps
// Top level of the input event frame phase stamper: sequencer, event queue and divider.
// Depends on ifps_pkg, ifps_ram and ifps_div.
//
// Usage: words arrive on the input channel (in_valid_i / in_ready_o). A button
// event word is taken while the sequencer is idle and, if it passes the enable,
// debounce and queue-full checks, is written into the event queue; it produces
// no output. A frame start word moves the frame boundaries (fallback check,
// fallback and span computation states) and then drains up to sixteen queued
// events. A drained event whose stamp falls strictly inside the frame passes
// through a queue read, a load and a compare state, the bit-serial divider
// (sixteen steps and the handoff) and the load of the output register; any
// other stamp skips the divider. While a frame start is being worked on,
// in_ready_o stays low; it is high whenever the sequencer is idle. Drained
// events leave on out_valid_o / out_ready_i from one output register; if the
// receiver stalls, the sequencer waits with the next result until the
// register is free. The last word of a drain carries last = 1. Reset clears
// the boundaries, the last press stamp and the queue pointers and loads the
// register defaults at once. Configuration writes take effect in the cycle
// after cfg_we_i is high.
module input_event_frame_phase_stamper_top
  import ifps_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o,
  input  logic        cfg_we_i,
  input  cfg_reg_e    cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FBCHK,
    S_FBFIX,
    S_SPAN,
    S_READ,
    S_LOAD,
    S_CMP,
    S_DIV,
    S_EMIT
  } state_e;

  // Configuration registers.
  logic        enable_q;
  logic        deb_en_q;
  logic [31:0] deb_ticks_q;
  logic [31:0] frame_ticks_q;

  // Sequencer state and frame bookkeeping.
  state_e          state_q;
  logic [63:0]     prev_q;
  logic [63:0]     cur_q;
  logic [63:0]     last_press_q;
  logic [63:0]     span_q;
  logic [63:0]     r_q;
  logic            low_q;
  logic            fb_q;
  logic [AW-1:0]   head_q;
  logic [CW-1:0]   count_q;
  logic [NW-1:0]   n_q;
  logic [PHASE_BITS:0] phase_q;
  logic            out_valid_q;
  out_word_t       out_q;

  // Event path signals.
  logic        accept;
  logic        ev_accept;
  logic        fr_accept;
  logic [63:0] press_gap;
  logic        bounce;
  logic        full;
  logic        push;
  logic [CW:0] tail_sum;
  logic [CW:0] tail_wrap;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_next;

  // Queue and divider connections.
  q_entry_t  wentry;
  q_entry_t  rentry;
  logic      ram_re;
  logic      div_start;
  div_rsp_t  div_rsp;

  logic [64:0] fb_diff;
  logic [64:0] r_diff;
  logic        out_free;
  logic        drain_done;

  assign accept    = in_valid_i && in_ready_o;
  assign ev_accept = accept && (in_data_i.cmd == CMD_EVENT);
  assign fr_accept = accept && (in_data_i.cmd == CMD_FRAME);

  // Debounce uses a wrapping 64-bit gap to the last accepted press.
  assign press_gap = in_data_i.stamp - last_press_q;
  assign bounce    = deb_en_q && in_data_i.is_press && (press_gap < {32'd0, deb_ticks_q});
  assign full      = (count_q >= CW'(QUEUE_DEPTH));
  assign push      = ev_accept && enable_q && !bounce && !full;

  assign tail_sum  = (CW + 1)'(head_q) + (CW + 1)'(count_q);
  assign tail_wrap = (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                     tail_sum - (CW + 1)'(QUEUE_DEPTH) : tail_sum;
  assign tail      = tail_wrap[AW-1:0];
  assign head_next = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

  assign wentry.player_two = in_data_i.second_player;
  assign wentry.press      = in_data_i.is_press;
  assign wentry.button     = in_data_i.button;
  assign wentry.stamp      = in_data_i.stamp;

  // Fallback: borrow out of cur - frame_ticks means frame_ticks is above cur.
  assign fb_diff = {1'b0, cur_q} - {33'd0, frame_ticks_q};
  // Offset of the event inside the frame; a borrow or zero means at or before prev.
  assign r_diff  = {1'b0, rentry.stamp} - {1'b0, prev_q};

  assign ram_re     = (state_q == S_READ);
  assign div_start  = (state_q == S_CMP) && !low_q && (r_q < span_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign drain_done = (count_q == '0) || (n_q == NW'(MAX_RESULTS));

  ifps_ram #(
    .WIDTH ($bits(q_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (tail),
    .wdata_i (wentry),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (rentry)
  );

  ifps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (r_q),
    .span_i  (span_q),
    .rsp_o   (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b1;
      deb_en_q      <= 1'b1;
      deb_ticks_q   <= RST_DEBOUNCE_TICKS;
      frame_ticks_q <= RST_FRAME_TICKS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:      enable_q      <= cfg_data_i[0];
        REG_DEB_ENABLE:  deb_en_q      <= cfg_data_i[0];
        REG_DEB_TICKS:   deb_ticks_q   <= cfg_data_i;
        REG_FRAME_TICKS: frame_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prev_q       <= '0;
      cur_q        <= '0;
      last_press_q <= '0;
      head_q       <= '0;
      count_q      <= '0;
      n_q          <= '0;
      fb_q         <= 1'b0;
      low_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // In S_EMIT the output register is either held or reloaded below.
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (ev_accept && enable_q && deb_en_q && in_data_i.is_press && !bounce) begin
            last_press_q <= in_data_i.stamp;
          end
          if (push) begin
            count_q <= count_q + 1'b1;
          end
          if (fr_accept) begin
            prev_q  <= cur_q;
            cur_q   <= in_data_i.stamp;
            state_q <= S_FBCHK;
          end
        end
        S_FBCHK: begin
          fb_q    <= (prev_q == '0) || (prev_q >= cur_q);
          state_q <= S_FBFIX;
        end
        S_FBFIX: begin
          if (fb_q) begin
            prev_q <= ((frame_ticks_q != '0) && !fb_diff[64]) ? fb_diff[63:0] : cur_q;
          end
          state_q <= S_SPAN;
        end
        S_SPAN: begin
          span_q  <= cur_q - prev_q;
          n_q     <= '0;
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= drain_done ? S_IDLE : S_LOAD;
        end
        S_LOAD: begin
          r_q     <= r_diff[63:0];
          low_q   <= r_diff[64] || (r_diff[63:0] == '0);
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (low_q) begin
            phase_q <= '0;
            state_q <= S_EMIT;
          end else if (r_q >= span_q) begin
            // Stamp at or after the current frame start.
            phase_q <= PHASE_ONE;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            phase_q <= {1'b0, div_rsp.quo};
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q            <= 1'b1;
            out_q.event_stamp      <= rentry.stamp;
            out_q.event_button     <= rentry.button;
            out_q.event_press      <= rentry.press;
            out_q.event_player_two <= rentry.player_two;
            out_q.phase            <= phase_q;
            out_q.last             <= (count_q == CW'(1)) || (n_q == NW'(MAX_RESULTS - 1));
            head_q                 <= head_next;
            count_q                <= count_q - 1'b1;
            n_q                    <= n_q + 1'b1;
            state_q                <= S_READ;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/ifps_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the input event frame phase stamper, with its bind.
// Depends on ifps_pkg and input_event_frame_phase_stamper_top.
module ifps_checker
  import ifps_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // A stalled output word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // A phase never exceeds one full frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.phase <= PHASE_ONE)
    else $error("phase above 1.0");

  // A frame start keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.cmd == CMD_FRAME |=> !in_ready_o)
    else $error("ready right after a frame start");

  // A button event never produces an output word by itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.cmd == CMD_EVENT && !out_valid_o
    |=> !out_valid_o)
    else $error("output word after a button event");

endmodule

bind input_event_frame_phase_stamper_top ifps_checker u_ifps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
